>>> rtl/lpfd_pkg.sv
// Shared types, constants and the header byte table for the frame deframer.
`default_nettype none
package lpfd_pkg;

   localparam int unsigned HEADER_BYTES = 9;
   localparam int unsigned LENGTH_BYTES = 4;

   localparam logic [1:0] STATUS_OK            = 2'd0;
   localparam logic [1:0] STATUS_NO_HEADER     = 2'd1;
   localparam logic [1:0] STATUS_SHORT_LENGTH  = 2'd2;
   localparam logic [1:0] STATUS_SHORT_PAYLOAD = 2'd3;

   typedef struct packed {
      logic [1:0] status;
      logic       stream_end;
      logic       frame_end;
      logic [7:0] byte_out;
      logic       has_byte;
   } rsp_type;

   // Expected header byte at each position; positions past the magic text expect zero.
   function automatic logic [7:0] magic_byte(input logic [3:0] pos);
      logic [7:0] value;
      case (pos)
         4'd0: value = 8'h4B;
         4'd1: value = 8'h56;
         4'd2: value = 8'h41;
         4'd3: value = 8'h49;
         4'd4: value = 8'h2D;
         4'd5: value = 8'h50;
         4'd6: value = 8'h42;
         4'd7: value = 8'h31;
         4'd8: value = 8'h0A;
         default: value = 8'h00;
      endcase
      return value;
   endfunction

endpackage
`default_nettype wire

>>> rtl/length_prefixed_frame_deframer.sv
// Top level: length-prefixed frame deframer with a two-entry output skid buffer.
// An accepted request's result is registered into the output entry, or into the skid entry while the sink stalls.
// Throughput: one byte per clock while req_tready is high; the parser state updates in the accept cycle.
// req_tready drops only when both output entries hold results the sink has not taken.
// Reset (synchronous, active high) returns the parser to header search and
// empties the output entries.
`default_nettype none
module length_prefixed_frame_deframer #(
   parameter int unsigned HEADER_BYTES = lpfd_pkg::HEADER_BYTES,
   parameter int unsigned LENGTH_BYTES = lpfd_pkg::LENGTH_BYTES
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output      logic       req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] byte_in
   input  wire logic       req_tlast,   // stream_last
   output      logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   output      logic [7:0] rsp_tdata,   // [7:0] byte_out
   output      logic       rsp_tlast,   // frame_end
   output      logic [3:0] rsp_tuser    // [0] has_byte, [1] stream_end, [3:2] status
);

   // Parser phases
   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_LENGTH  = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;
   localparam logic [1:0] PH_DROP    = 2'd3;

   localparam logic [4:0] HEADER_END = 5'(HEADER_BYTES);
   localparam logic [1:0] LENGTH_LAST = 2'(LENGTH_BYTES - 1);

   logic [1:0]  phase_ff, phase_in;
   logic [3:0]  header_pos_ff, header_pos_in;
   logic [1:0]  length_pos_ff, length_pos_in;
   logic [31:0] length_accum_ff, length_accum_in;
   logic [31:0] bytes_left_ff, bytes_left_in;

   logic              out_valid_ff, out_valid_in;
   lpfd_pkg::rsp_type out_ff, out_in;
   logic              skid_valid_ff, skid_valid_in;
   lpfd_pkg::rsp_type skid_ff, skid_in;

   logic              accept;
   logic              take;
   logic              res_valid;
   lpfd_pkg::rsp_type res;
   logic              rearm;
   logic [4:0]        header_next;
   logic [31:0]       accum_merged;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign take       = out_valid_ff && rsp_tready;

   assign header_next = {1'b0, header_pos_ff} + 5'd1;

   // Drop the incoming length byte into its lane, little endian.
   always_comb begin
      accum_merged = length_accum_ff;
      case (length_pos_ff)
         2'd0:    accum_merged[7:0]   = length_accum_ff[7:0]   | req_tdata;
         2'd1:    accum_merged[15:8]  = length_accum_ff[15:8]  | req_tdata;
         2'd2:    accum_merged[23:16] = length_accum_ff[23:16] | req_tdata;
         default: accum_merged[31:24] = length_accum_ff[31:24] | req_tdata;
      endcase
   end

   // Parser: next state and the result (if any) for the byte at the input.
   always_comb begin
      phase_in        = phase_ff;
      header_pos_in   = header_pos_ff;
      length_pos_in   = length_pos_ff;
      length_accum_in = length_accum_ff;
      bytes_left_in   = bytes_left_ff;
      res_valid       = 1'b0;
      res             = '0;
      rearm           = 1'b0;

      case (phase_ff)
         PH_HEADER: begin
            if (req_tdata != lpfd_pkg::magic_byte(header_pos_ff)) begin
               res_valid  = 1'b1;
               res.status = lpfd_pkg::STATUS_NO_HEADER;
               if (req_tlast) begin
                  rearm = 1'b1;
               end else begin
                  phase_in = PH_DROP;
               end
            end else begin
               header_pos_in = header_next[3:0];
               if (header_next >= HEADER_END) begin
                  phase_in        = PH_LENGTH;
                  length_pos_in   = '0;
                  length_accum_in = '0;
                  if (req_tlast) begin
                     // header alone is a clean, empty stream
                     rearm          = 1'b1;
                     res_valid      = 1'b1;
                     res.stream_end = 1'b1;
                     res.status     = lpfd_pkg::STATUS_OK;
                  end
               end else if (req_tlast) begin
                  rearm      = 1'b1;
                  res_valid  = 1'b1;
                  res.status = lpfd_pkg::STATUS_NO_HEADER;
               end
            end
         end

         PH_LENGTH: begin
            length_accum_in = accum_merged;
            if (length_pos_ff == LENGTH_LAST) begin
               length_pos_in = '0;
               if (accum_merged == 32'd0) begin
                  // empty frame: frame end with no byte
                  res_valid     = 1'b1;
                  res.frame_end = 1'b1;
                  if (req_tlast) begin
                     rearm          = 1'b1;
                     res.stream_end = 1'b1;
                  end
               end else begin
                  bytes_left_in   = accum_merged;
                  length_accum_in = '0;
                  phase_in        = PH_PAYLOAD;
                  if (req_tlast) begin
                     rearm      = 1'b1;
                     res_valid  = 1'b1;
                     res.status = lpfd_pkg::STATUS_SHORT_PAYLOAD;
                  end
               end
            end else begin
               length_pos_in = length_pos_ff + 2'd1;
               if (req_tlast) begin
                  rearm      = 1'b1;
                  res_valid  = 1'b1;
                  res.status = lpfd_pkg::STATUS_SHORT_LENGTH;
               end
            end
         end

         PH_PAYLOAD: begin
            res_valid    = 1'b1;
            res.has_byte = 1'b1;
            res.byte_out = req_tdata;
            if (bytes_left_ff <= 32'd1) begin
               bytes_left_in   = '0;
               phase_in        = PH_LENGTH;
               length_pos_in   = '0;
               length_accum_in = '0;
               res.frame_end   = 1'b1;
               if (req_tlast) begin
                  rearm          = 1'b1;
                  res.stream_end = 1'b1;
               end
            end else begin
               bytes_left_in = bytes_left_ff - 32'd1;
               if (req_tlast) begin
                  rearm      = 1'b1;
                  res.status = lpfd_pkg::STATUS_SHORT_PAYLOAD;
               end
            end
         end

         default: begin
            // dropping the rest of a failed stream
            if (req_tlast) begin
               rearm = 1'b1;
            end
         end
      endcase

      if (rearm) begin
         phase_in        = PH_HEADER;
         header_pos_in   = '0;
         length_pos_in   = '0;
         length_accum_in = '0;
         bytes_left_in   = '0;
      end
   end

   // Output entry plus skid entry; the skid fills only while the sink stalls.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept && res_valid;
            out_in       = res;
         end
      end else if (accept && res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         header_pos_ff   <= '0;
         length_pos_ff   <= '0;
         length_accum_ff <= '0;
         bytes_left_ff   <= '0;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff        <= phase_in;
            header_pos_ff   <= header_pos_in;
            length_pos_ff   <= length_pos_in;
            length_accum_ff <= length_accum_in;
            bytes_left_ff   <= bytes_left_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.byte_out;
   assign rsp_tlast  = out_ff.frame_end;
   assign rsp_tuser  = {out_ff.status, out_ff.stream_end, out_ff.has_byte};

endmodule
`default_nettype wire

>>> rtl/lpfd_checker.sv
// Port-level checker for the frame deframer and its bind to the top level.
`default_nettype none
module lpfd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast,
   input wire logic [3:0] rsp_tuser
);

   // No result leaves the block right after reset.
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result holds its payload.
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Results without a byte carry zero data.
   a_empty_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 8'd0)
      else $error("data on a result without a byte");

   // Error results never mark a frame or stream end.
   a_error_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3:2] != lpfd_pkg::STATUS_OK |-> !rsp_tlast && !rsp_tuser[1])
      else $error("error result with an end flag");

   // A clean stream end carrying a byte must close its frame.
   a_clean_end_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] && rsp_tuser[0] |-> rsp_tlast)
      else $error("stream ended inside a frame");

endmodule

bind length_prefixed_frame_deframer lpfd_checker u_lpfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
